FILE: sv/md5d_pkg.sv
// md5d_pkg: shared types, constants and helper functions of the MD5 digest block.
// No dependencies; compiled first.
package md5d_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5d_regs_t;

  localparam md5d_regs_t MD5_INIT = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476
  };

  localparam logic [31:0] PAD_BYTE   = 32'h0000_0080;
  localparam logic [3:0]  LEN_LO_POS = 4'd14;
  localparam logic [3:0]  LAST_POS   = 4'd15;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] STEP_SHIFT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by round j.
  function automatic logic [3:0] msg_index(input logic [5:0] j);
    logic [3:0] jl;
    logic [3:0] idx;
    begin
      jl = j[3:0];
      case (j[5:4])
        2'd0:    idx = jl;
        2'd1:    idx = 4'(5 * jl + 1);
        2'd2:    idx = 4'(3 * jl + 5);
        default: idx = 4'(7 * jl);
      endcase
      return idx;
    end
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    begin
      dbl = {x, x} << s;
      return dbl[63:32];
    end
  endfunction

endpackage

FILE: sv/md5d_if.sv
// md5d_in_if / md5d_out_if: valid/ready channels of the MD5 digest block.
// No dependencies.
interface md5d_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, output word, output valid_bytes, output last_word,
                  input ready);
  modport sink (input valid, input word, input valid_bytes, input last_word,
                output ready);
endinterface

interface md5d_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_of_digest;

  modport source (output valid, output digest_word, output word_index,
                  output last_of_digest, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_of_digest, output ready);
endinterface

FILE: sv/md5d_round.sv
// md5d_round: one MD5 step (round function, add, rotate) shared by all 64 rounds.
// Depends on md5d_pkg.
module md5d_round (
  input  md5d_pkg::md5d_regs_t cur,
  input  logic [31:0]          km,
  input  logic [5:0]           round,
  output md5d_pkg::md5d_regs_t nxt
);
  import md5d_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;

  always_comb begin
    case (round[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
  end

  // km already holds K[j] + M[g(j)]
  assign sum = cur.a + f + km;
  assign rot = rotl32(sum, STEP_SHIFT[{round[5:4], round[1:0]}]);

  assign nxt.a = cur.d;
  assign nxt.b = cur.b + rot;
  assign nxt.c = cur.b;
  assign nxt.d = cur.c;

endmodule

FILE: sv/md5_digest_top.sv
// MD5 digest: a word not closing a block is only stored; a word that fills a block
// then runs K+M prefetch, 64 rounds on the shared step unit and the chaining add.
// The last word adds one pad word per cycle and one or two block passes, then
// four digest transfers, one per cycle while the receiver is ready.
// Synchronous reset loads the initial chaining values and clears all counters.
module md5_digest_top (
  input logic         clk,
  input logic         rst,
  md5d_in_if.sink     msg,
  md5d_out_if.source  digest
);
  import md5d_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_BYTE = 2'd1;
  localparam logic [1:0] PH_ZERO = 2'd2;
  localparam logic [1:0] PH_HI   = 2'd3;

  logic [2:0]  state;
  logic [31:0] blk [16];
  md5d_regs_t  chain;
  md5d_regs_t  regs;
  md5d_regs_t  regs_next;
  logic [3:0]  wib;
  logic [63:0] bit_count;
  logic [5:0]  round;
  logic [1:0]  phase;
  logic [1:0]  oidx;
  logic [31:0] km;
  logic [31:0] km_next;
  logic [5:0]  jn;

  logic        accept;
  logic        out_xfer;
  logic [2:0]  n_eff;
  logic [31:0] in_word;
  logic [5:0]  in_bits;
  logic [31:0] pad_word;
  logic        wr_en;
  logic [31:0] wr_data;

  assign msg.ready = (state == S_IDLE);
  assign accept    = msg.valid && msg.ready;
  assign out_xfer  = digest.valid && digest.ready;

  always_comb begin
    n_eff = FULL_BYTES;
    if (msg.last_word && msg.valid_bytes < FULL_BYTES) begin
      n_eff = msg.valid_bytes;
    end
    case (n_eff)
      3'd0:    in_word = PAD_BYTE;
      3'd1:    in_word = {16'h0, PAD_BYTE[7:0], msg.word[7:0]};
      3'd2:    in_word = {8'h0, PAD_BYTE[7:0], msg.word[15:0]};
      3'd3:    in_word = {PAD_BYTE[7:0], msg.word[23:0]};
      default: in_word = msg.word;
    endcase
    in_bits = {n_eff, 3'b000};
  end

  always_comb begin
    if (phase == PH_BYTE) begin
      pad_word = PAD_BYTE;
    end else if (phase == PH_HI) begin
      pad_word = bit_count[63:32];
    end else if (wib == LEN_LO_POS) begin
      pad_word = bit_count[31:0];
    end else begin
      pad_word = 32'h0;
    end
  end

  assign wr_en   = accept || (state == S_PAD);
  assign wr_data = accept ? in_word : pad_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk[wib] <= wr_data;
    end
  end

  assign jn      = (state == S_RUN) ? round + 6'd1 : 6'd0;
  assign km_next = SINE_K[jn] + blk[msg_index(jn)];

  md5d_round u_round (
    .cur   (regs),
    .km    (km),
    .round (round),
    .nxt   (regs_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chain     <= MD5_INIT;
      regs      <= MD5_INIT;
      wib       <= '0;
      bit_count <= '0;
      round     <= '0;
      phase     <= PH_NONE;
      oidx      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            wib       <= wib + 4'd1;
            bit_count <= bit_count + 64'(in_bits);
            if (!msg.last_word) begin
              phase <= PH_NONE;
            end else if (n_eff == FULL_BYTES) begin
              phase <= PH_BYTE;
            end else begin
              phase <= PH_ZERO;
            end
            if (wib == LAST_POS) begin
              state <= S_PRE;
            end else if (msg.last_word) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          wib <= wib + 4'd1;
          if (phase == PH_BYTE) begin
            phase <= PH_ZERO;
          end else if (phase == PH_ZERO && wib == LEN_LO_POS) begin
            phase <= PH_HI;
          end
          if (wib == LAST_POS) begin
            state <= S_PRE;
          end
        end
        S_PRE: begin
          regs  <= chain;
          round <= '0;
          km    <= km_next;
          state <= S_RUN;
        end
        S_RUN: begin
          regs  <= regs_next;
          km    <= km_next;
          round <= round + 6'd1;
          if (round == LAST_ROUND) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          chain.a <= chain.a + regs.a;
          chain.b <= chain.b + regs.b;
          chain.c <= chain.c + regs.c;
          chain.d <= chain.d + regs.d;
          case (phase)
            PH_NONE: state <= S_IDLE;
            PH_HI:   state <= S_OUT;
            default: state <= S_PAD;
          endcase
        end
        S_OUT: begin
          if (out_xfer) begin
            oidx <= oidx + 2'd1;
            if (oidx == 2'd3) begin
              chain     <= MD5_INIT;
              regs      <= MD5_INIT;
              wib       <= '0;
              bit_count <= '0;
              phase     <= PH_NONE;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digest.valid          = (state == S_OUT);
  assign digest.word_index     = oidx;
  assign digest.last_of_digest = (oidx == 2'd3);

  always_comb begin
    case (oidx)
      2'd0:    digest.digest_word = chain.a;
      2'd1:    digest.digest_word = chain.b;
      2'd2:    digest.digest_word = chain.c;
      default: digest.digest_word = chain.d;
    endcase
  end

endmodule

FILE: tb/md5_digest_checker.sv
// md5_digest_checker: watches both channels of md5_digest_top, predicts the digest words of
// every message that completes on the input channel and compares each output transfer.
// Depends on md5d_in_if / md5d_out_if.
module md5_digest_checker (
  input  logic clk,
  input  logic rst,
  md5d_in_if   msg,
  md5d_out_if  digest,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_of_digest;
  } digest_beat_t;

  localparam logic [31:0] IV_WORD [4] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476};
  localparam logic [31:0] PAD_MARK = 32'h0000_0080;
  localparam int unsigned ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                           4, 11, 16, 23, 6, 10, 15, 21};
  localparam int unsigned LEN_SLOT  = 14;
  localparam int unsigned FULL_WORD = 4;
  localparam int MAX_SHOWN = 10;

  logic [31:0]  sine_tab [64];
  logic [31:0]  chain [4];
  logic [31:0]  blk [16];
  int unsigned  fill;
  logic [63:0]  bit_len;
  digest_beat_t digest_q [$];
  int           mism;

  initial begin
    real    r;
    longint lk;
    for (int i = 0; i < 64; i++) begin
      r = $sin(i + 1.0);
      if (r < 0.0) r = -r;
      lk = $floor(r * 4294967296.0);
      sine_tab[i] = lk[31:0];
    end
    for (int k = 0; k < 4; k++) chain[k] = IV_WORD[k];
    for (int k = 0; k < 16; k++) blk[k] = '0;
    fill = 0;
    bit_len = '0;
    mism = 0;
    fail_count <= 0;
    outstanding <= 0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic compress_block();
    logic [31:0] a, b, c, d, f, t;
    int unsigned g;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int unsigned j = 0; j < 64; j++) begin
      case (j / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = j;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * j + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * j + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * j) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + sine_tab[j] + blk[g], ROT_AMT[((j / 16) * 4) + (j % 4)]);
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endtask

  task automatic append_word(input logic [31:0] w);
    blk[fill] = w;
    fill++;
    if (fill == 16) begin
      compress_block();
      fill = 0;
    end
  endtask

  task automatic absorb_item(input logic [31:0] w, input logic [2:0] nb, input logic lst);
    int unsigned  n;
    logic [31:0]  keep;
    digest_beat_t e;
    if (!lst) begin
      append_word(w);
      bit_len += 64'd32;
      return;
    end
    n = (nb > FULL_WORD) ? FULL_WORD : nb;
    if (n == FULL_WORD) begin
      append_word(w);
      bit_len += 64'd32;
      append_word(PAD_MARK);
    end else begin
      keep = (n == 0) ? '0 : (32'h1 << (8 * n)) - 32'h1;
      append_word((w & keep) | (PAD_MARK << (8 * n)));
      bit_len += 64'(8 * n);
    end
    while (fill != LEN_SLOT) append_word('0);
    append_word(bit_len[31:0]);
    append_word(bit_len[63:32]);
    for (int k = 0; k < 4; k++) begin
      e.digest_word = chain[k];
      e.word_index = 2'(k);
      e.last_of_digest = (k == 3);
      digest_q.push_back(e);
    end
    for (int k = 0; k < 4; k++) chain[k] = IV_WORD[k];
    fill = 0;
    bit_len = '0;
  endtask

  always @(posedge clk) begin
    digest_beat_t got, want;
    if (!rst) begin
      if (msg.valid && msg.ready) absorb_item(msg.word, msg.valid_bytes, msg.last_word);
      if (digest.valid && digest.ready) begin
        got.digest_word = digest.digest_word;
        got.word_index = digest.word_index;
        got.last_of_digest = digest.last_of_digest;
        if (digest_q.size() == 0) begin
          if (mism < MAX_SHOWN)
            $display("%0t: digest transfer with none expected: word %h index %0d last %0b",
                     $realtime, got.digest_word, got.word_index, got.last_of_digest);
          mism++;
        end else begin
          want = digest_q.pop_front();
          if (got !== want) begin
            if (mism < MAX_SHOWN)
              $display("%0t: digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b", $realtime,
                       want.digest_word, want.word_index, want.last_of_digest,
                       got.digest_word, got.word_index, got.last_of_digest);
            mism++;
          end
        end
      end
      fail_count <= mism;
      outstanding <= digest_q.size();
    end
  end

endmodule

FILE: tb/md5_digest_top_tb.sv
// md5_digest_top_tb: drives messages into md5_digest_top with bursty input and a stalling
// digest receiver; md5_digest_checker predicts and compares. Depends on md5d_pkg, md5d_if,
// md5_digest_top and md5_digest_checker.
module md5_digest_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS = 225;
  localparam int unsigned TAIL_CYCLES  = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   outstanding;
  int unsigned hold_ask = 0;
  int unsigned hold_seen = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;

  md5d_in_if  msg_ch ();
  md5d_out_if dig_ch ();

  md5_digest_top dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  md5_digest_checker digest_chk (
    .clk         (clk),
    .rst         (rst),
    .msg         (msg_ch),
    .digest      (dig_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        msg_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    msg_ch.valid <= 1'b1;
    msg_ch.word <= w;
    msg_ch.valid_bytes <= nb;
    msg_ch.last_word <= lst;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_results();
    msg_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_message(input int unsigned body_words, input logic [2:0] tail_bytes);
    for (int unsigned i = 0; i < body_words; i++)
      send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
    send_word(rand_word(), tail_bytes, 1'b1);
  endtask

  // receiver: random ready patterns, plus a long hold-off on request
  initial begin
    int unsigned mode, seg;
    logic r;
    dig_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg = $urandom_range(8, 80);
      repeat (seg) begin
        if (hold_ask != hold_seen) begin
          hold_seen = hold_ask;
          dig_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       r = 1'b1;
          1:       r = 1'($urandom_range(0, 1));
          2:       r = ($urandom_range(0, 3) == 0);
          default: r = ($urandom_range(0, 3) != 0);
        endcase
        dig_ch.ready <= r;
        @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned msg_cnt, body, first_random;
    msg_ch.valid <= 1'b0;
    msg_ch.word <= '0;
    msg_ch.valid_bytes <= '0;
    msg_ch.last_word <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty message, partial tails with junk above the valid bytes, oversize byte counts
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    send_word(32'hFF63_6261, 3'd3, 1'b1);
    send_word(32'hAAAA_AAAA, 3'd1, 1'b1);
    send_word(32'h5555_5555, 3'd2, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    send_word(32'h0000_0000, 3'd5, 1'b1);
    send_word(32'h1234_5678, 3'd6, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    // 56-byte message: length no longer fits, extra pad block; partial counts mid-message
    for (int i = 0; i < 13; i++)
      send_word((i % 2 != 0) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'(i % 4), 1'b0);
    send_word(32'h8000_0001, 3'd4, 1'b1);
    wait_results();

    hold_ask++;
    msg_cnt = 0;
    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      if (msg_cnt == 12) hold_ask++;
      if (msg_cnt < 4 || (msg_cnt >= 12 && msg_cnt < 16)) begin
        body = $urandom_range(0, 3);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: body = $urandom_range(0, 4);
          4, 5, 6:    body = $urandom_range(12, 17);
          7, 8:       body = $urandom_range(5, 31);
          default:    body = $urandom_range(30, 48);
        endcase
      end
      send_message(body, 3'($urandom_range(0, 7)));
      msg_cnt++;
      if ($urandom_range(0, 5) == 0) wait_results();
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
